FILE: rtl/olad_pkg.sv
`default_nettype none

package olad_pkg;

   // node store size and derived widths
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int PTR_W    = IDX_W + 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ELEM_W   = 32;
   localparam int ACT_W    = 2;
   localparam int STATUS_W = 3;

   // null link: top bit set, outside the slot range
   localparam logic [PTR_W-1:0] NULL_PTR = {1'b1, {IDX_W{1'b0}}};

   // actions
   localparam logic [ACT_W-1:0] ACT_APPEND   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ_FWD = 2'd2;
   localparam logic [ACT_W-1:0] ACT_READ_BWD = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ELEMENT   = 3'd4;

   // one result handed from the walker to the output stage
   typedef struct packed {
      logic                     valid;
      logic [STATUS_W-1:0]      status;
      logic signed [ELEM_W-1:0] element;
      logic                     last;
   } emit_type;

endpackage

`default_nettype wire

FILE: rtl/olad_ram.sv
`default_nettype none

module olad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/olad_walk.sv
`default_nettype none

module olad_walk
   import olad_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ACT_W-1:0]         req_action,
   input  wire logic signed [ELEM_W-1:0] req_value,
   input  wire logic                     out_free,
   output emit_type                      emit
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WAIT = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [ACT_W-1:0]         op_ff, op_in;
   logic signed [ELEM_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0]         cur_ff, cur_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CAPACITY-1:0]      mask_ff, mask_in;
   logic [STATUS_W-1:0]      resp_ff, resp_in;

   logic [IDX_W-1:0]  rd_addr;
   logic              val_we, nxt_we, prv_we;
   logic [IDX_W-1:0]  val_wa, nxt_wa, prv_wa;
   logic [ELEM_W-1:0] val_wd, val_rd;
   logic [PTR_W-1:0]  nxt_wd, prv_wd, nxt_rd, prv_rd;

   logic [IDX_W-1:0] free_slot;
   logic [PTR_W-1:0] start_ptr;
   logic [PTR_W-1:0] step_ptr;

   olad_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_val (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_addr(rd_addr), .rd_data(val_rd)
   );

   olad_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_nxt (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(rd_addr), .rd_data(nxt_rd)
   );

   olad_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_prv (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(rd_addr), .rd_data(prv_rd)
   );

   // lowest clear bit of the in-use mask
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!mask_ff[i]) begin
            free_slot = IDX_W'(i);
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign start_ptr = (req_action == ACT_READ_BWD) ? tail_ff : head_ff;
   assign step_ptr  = (op_ff == ACT_READ_FWD) ? nxt_rd : prv_rd;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      cur_in   = cur_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      mask_in  = mask_ff;
      resp_in  = resp_ff;
      rd_addr  = cur_ff[IDX_W-1:0];
      val_we   = 1'b0;
      val_wa   = free_slot;
      val_wd   = req_value;
      nxt_we   = 1'b0;
      nxt_wa   = free_slot;
      nxt_wd   = NULL_PTR;
      prv_we   = 1'b0;
      prv_wa   = free_slot;
      prv_wd   = tail_ff;
      emit     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_action;
               key_in = req_value;
               if (req_action == ACT_APPEND) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     resp_in  = STATUS_FULL;
                     state_in = S_RESP;
                  end else begin
                     // new node: value, null forward link, back link to old tail
                     val_we   = 1'b1;
                     nxt_we   = 1'b1;
                     prv_we   = 1'b1;
                     cur_in   = tail_ff;
                     tail_in  = {1'b0, free_slot};
                     mask_in[free_slot] = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     if (!tail_ff[PTR_W-1]) begin
                        state_in = S_LINK;
                     end else begin
                        head_in  = {1'b0, free_slot};
                        resp_in  = STATUS_DONE;
                        state_in = S_RESP;
                     end
                  end
               end else if (count_ff == '0) begin
                  resp_in  = STATUS_EMPTY;
                  state_in = S_RESP;
               end else begin
                  rd_addr  = start_ptr[IDX_W-1:0];
                  cur_in   = start_ptr;
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (op_ff == ACT_DELETE) begin
               if (val_rd == key_ff) begin
                  // unlink the matching node
                  if (!nxt_rd[PTR_W-1]) begin
                     prv_we = 1'b1;
                     prv_wa = nxt_rd[IDX_W-1:0];
                     prv_wd = prv_rd;
                  end else begin
                     tail_in = prv_rd;
                  end
                  if (!prv_rd[PTR_W-1]) begin
                     nxt_we = 1'b1;
                     nxt_wa = prv_rd[IDX_W-1:0];
                     nxt_wd = nxt_rd;
                  end else begin
                     head_in = nxt_rd;
                  end
                  mask_in[cur_ff[IDX_W-1:0]] = 1'b0;
                  count_in = count_ff - CNT_W'(1);
                  resp_in  = STATUS_DONE;
                  state_in = S_RESP;
               end else if (!nxt_rd[PTR_W-1]) begin
                  rd_addr = nxt_rd[IDX_W-1:0];
                  cur_in  = nxt_rd;
               end else begin
                  resp_in  = STATUS_NOT_FOUND;
                  state_in = S_RESP;
               end
            end else if (out_free) begin
               emit.valid   = 1'b1;
               emit.status  = STATUS_ELEMENT;
               emit.element = val_rd;
               emit.last    = step_ptr[PTR_W-1];
               if (!step_ptr[PTR_W-1]) begin
                  rd_addr = step_ptr[IDX_W-1:0];
                  cur_in  = step_ptr;
               end else begin
                  state_in = S_IDLE;
               end
            end
            // output stage busy: re-read the same node
         end
         S_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = cur_ff[IDX_W-1:0];
            nxt_wd   = tail_ff;
            resp_in  = STATUS_DONE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = resp_ff;
               emit.last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NULL_PTR;
         tail_ff  <= NULL_PTR;
         count_ff <= '0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         mask_ff  <= mask_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      cur_ff  <= cur_in;
      resp_ff <= resp_in;
   end

   a_count_mask: assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) == int'(count_ff))
      else $error("entry count disagrees with in-use mask");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == NULL_PTR && tail_ff == NULL_PTR))
      else $error("empty list with live head or tail");

   a_head_used: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (!head_ff[PTR_W-1] && !tail_ff[PTR_W-1]
                            && mask_ff[head_ff[IDX_W-1:0]] && mask_ff[tail_ff[IDX_W-1:0]]))
      else $error("head or tail points at a free slot");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_action == ACT_APPEND
       && count_ff != CNT_W'(CAPACITY)) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the list");

endmodule

`default_nettype wire

FILE: rtl/olad_rsp.sv
`default_nettype none

module olad_rsp
   import olad_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire emit_type            emit,
   input  wire logic                rsp_stall,
   output logic                     out_free,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [ELEM_W-1:0] rsp_element,
   output logic                     rsp_last
);

   logic                     valid_ff, valid_in;
   logic [STATUS_W-1:0]      status_ff;
   logic signed [ELEM_W-1:0] element_ff;
   logic                     last_ff;

   // free when empty or being taken this cycle
   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = emit.valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (emit.valid) begin
         status_ff  <= emit.status;
         element_ff <= emit.element;
         last_ff    <= emit.last;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

FILE: rtl/ordered_list_append_delete_top.sv
// append answers through the response state, via a link state when an old tail is joined;
// delete visits nodes from the head in turn, up to CAPACITY, then answers
// read gives one element per cycle while not stalled, from the node store, up to CAPACITY
// one item at a time; next item is taken once its last result sits in the output register
// reset (synchronous, active high) empties the list at once; the node store needs no clear
`default_nettype none

module ordered_list_append_delete_top
   import olad_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ACT_W-1:0]         req_action,
   input  wire logic signed [ELEM_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [ELEM_W-1:0]      rsp_element,
   output logic                          rsp_last
);

   // result from the walker, and back-pressure from the output register
   emit_type emit;
   logic     out_free;

   // sequencer with the three node memories (values, forward, backward links)
   olad_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_action(req_action),
      .req_value (req_value),
      .out_free  (out_free),
      .emit      (emit)
   );

   // output register: holds a result until its transfer completes
   olad_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .rsp_stall  (rsp_stall),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_element(rsp_element),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire
